// ----- rtl/piecewise_linear_table_interpolator_core_defines.svh -----
// assertion macros for the table interpolator
`ifndef PIECEWISE_LINEAR_TABLE_INTERPOLATOR_CORE_DEFINES_SVH
`define PIECEWISE_LINEAR_TABLE_INTERPOLATOR_CORE_DEFINES_SVH
`ifndef SYNTH
`define PLTI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("plti assertion failed");
`define PLTI_ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("plti assertion failed");
`else
`define PLTI_ASSERT(lbl, clk, rst_n, prop)
`define PLTI_ASSERT_CLK(lbl, clk, prop)
`endif
`endif

// ----- rtl/plti_pkg.sv -----
// shared types, constants and helpers of the table interpolator
package plti_pkg;

    localparam int ACT_W    = 2;
    localparam int STAT_W   = 2;
    localparam int POS_W    = 24;
    localparam int VAL_W    = 24;
    localparam int AREA_W   = 40;
    localparam int INTERP_W = 42;
    localparam int WIDE_W   = 52;
    localparam int APROD_W  = 51;
    localparam int MAG_W    = 41;
    localparam int NUM_W    = 25;
    localparam int PROD_W   = 66;
    localparam int Q_W      = 41;

    localparam logic [ACT_W-1:0] ACT_APPEND  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_VALUE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_AVERAGE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL       = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO_WIDTH = 2'd2;

    localparam logic signed [AREA_W-1:0] AREA_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [AREA_W-1:0] AREA_MIN = 40'sh80_0000_0000;

    typedef struct packed {
        logic [POS_W-1:0]         pos;
        logic [VAL_W-1:0]         val;
        logic signed [AREA_W-1:0] area;
    } t_entry;

    typedef struct packed {
        logic                     active;
        logic                     use_area;
        logic                     found;
        logic [POS_W-1:0]         x;
        logic [POS_W-1:0]         lo;
        logic [POS_W-1:0]         hi;
        logic signed [AREA_W-1:0] e0;
        logic signed [AREA_W-1:0] e1;
    } t_rec;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mag;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] den;
    } t_md_req;

    function automatic logic signed [AREA_W-1:0] sat_area(input logic signed [WIDE_W-1:0] v);
        logic signed [AREA_W-1:0] r;
        if (v > WIDE_W'(AREA_MAX)) begin
            r = AREA_MAX;
        end else if (v < WIDE_W'(AREA_MIN)) begin
            r = AREA_MIN;
        end else begin
            r = v[AREA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/plti_req_if.sv -----
// request channel of the table interpolator
interface plti_req_if import plti_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] upper_position;
    logic [VAL_W-1:0] point_value;

    modport source (output valid, action, position, upper_position, point_value, input ready);
    modport sink (input valid, action, position, upper_position, point_value, output ready);
endinterface

// ----- rtl/plti_rsp_if.sv -----
// result channel of the table interpolator
interface plti_rsp_if import plti_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [AREA_W-1:0] result_value;
    logic [STAT_W-1:0]        status;

    modport source (output valid, result_value, status, input ready);
    modport sink (input valid, result_value, status, output ready);
endinterface

// ----- rtl/plti_cell.sv -----
// one breakpoint cell: holds an entry and tests the passing query against its segment
module plti_cell import plti_pkg::*; #(
    parameter int          IDX       = 0,
    parameter int          IDX_W     = 8,
    parameter logic [23:0] RESET_VAL = 24'h010000
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_entry           i_wr_entry,
    input  t_rec             i_rec,
    input  t_entry           i_next_entry,
    input  logic             i_next_valid,
    output t_rec             o_rec,
    output t_entry           o_entry,
    output logic             o_valid
);

    logic   r_valid;
    t_entry r_entry;
    t_rec   r_rec;
    t_rec   n_rec;
    logic   wr_hit;
    logic signed [AREA_W-1:0] own_e;
    logic signed [AREA_W-1:0] next_e;

    assign wr_hit = i_wr_en && (i_wr_idx == IDX_W'(IDX));

    always_comb begin
        own_e  = i_rec.use_area ? r_entry.area : $signed(AREA_W'(r_entry.val));
        next_e = i_rec.use_area ? i_next_entry.area : $signed(AREA_W'(i_next_entry.val));
        n_rec  = i_rec;
        if (i_rec.active && !i_rec.found && r_valid) begin
            n_rec.e0 = own_e;
            if (i_next_valid && i_rec.x >= r_entry.pos && i_rec.x < i_next_entry.pos) begin
                n_rec.found = 1'b1;
                n_rec.lo    = r_entry.pos;
                n_rec.hi    = i_next_entry.pos;
                n_rec.e1    = next_e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= (IDX == 0);
            r_rec   <= '0;
        end else begin
            r_rec <= n_rec;
            if (wr_hit) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n && IDX == 0) begin
            r_entry.pos  <= '0;
            r_entry.val  <= RESET_VAL;
            r_entry.area <= '0;
        end else if (wr_hit) begin
            r_entry <= i_wr_entry;
        end
    end

    assign o_rec   = r_rec;
    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

// ----- rtl/plti_muldiv.sv -----
// shift-add multiply then restoring divide: floor(mag * num / den), clamped to 2^40
module plti_muldiv import plti_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_md_req        i_req,
    output logic           o_done,
    output logic [Q_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(PROD_W + 1);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_mcand;
    logic [NUM_W-1:0]  r_mplier;
    logic [PROD_W-1:0] r_prod;
    logic [NUM_W-1:0]  r_den;
    logic [NUM_W-1:0]  r_rem;
    logic [PROD_W-1:0] r_quot;
    logic [NUM_W:0]    rem_sh;
    logic              q_bit;

    always_comb begin
        rem_sh = {r_rem, r_prod[PROD_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req.start) begin
                        r_state <= ST_MUL;
                        r_cnt   <= '0;
                    end
                end
                ST_MUL: begin
                    if (r_cnt == CNT_W'(NUM_W - 1)) begin
                        r_state <= ST_DIV;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DIV: begin
                    if (r_cnt == CNT_W'(PROD_W - 1)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_req.start) begin
            r_mcand  <= PROD_W'(i_req.mag);
            r_mplier <= i_req.num;
            r_den    <= i_req.den;
            r_prod   <= '0;
        end else if (r_state == ST_MUL) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + r_mcand;
            end
            r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[NUM_W-1:1]};
            r_rem    <= '0;
        end else if (r_state == ST_DIV) begin
            r_rem  <= q_bit ? NUM_W'(rem_sh - {1'b0, r_den}) : rem_sh[NUM_W-1:0];
            r_prod <= {r_prod[PROD_W-2:0], 1'b0};
            r_quot <= {r_quot[PROD_W-2:0], q_bit};
        end
    end

    assign o_done = (r_state == ST_DONE);
    assign o_quot = (|r_quot[PROD_W-1:Q_W-1]) ? {1'b1, {(Q_W-1){1'b0}}} : r_quot[Q_W-1:0];

endmodule

// ----- rtl/piecewise_linear_table_interpolator_core.sv -----
// piecewise linear table interpolator with running trapezoid area
// append: area product registered in AMUL, entry written in AADD, result loaded in FINISH
// value query: a scan through the cell chain, then a muldiv run
// average query: two scans and three muldiv runs at most
// one request at a time; the next is taken while the result waits in the output register
// synchronous reset leaves the single point (0, 1.0, area 0) in the table
`include "piecewise_linear_table_interpolator_core_defines.svh"
module piecewise_linear_table_interpolator_core import plti_pkg::*; #(
    parameter int TABLE_DEPTH   = 256,
    parameter int FRACTION_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    plti_req_if.sink     i_req,
    plti_rsp_if.source   o_rsp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [VAL_W-1:0] RESET_VAL =
        (FRACTION_BITS >= VAL_W) ? {VAL_W{1'b1}} : VAL_W'(1 << FRACTION_BITS);
    localparam logic [Q_W-1:0] AVG_LIM = Q_W'(1) << (AREA_W - 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_AMUL   = 4'd1;
    localparam logic [3:0] ST_AADD   = 4'd2;
    localparam logic [3:0] ST_SCAN   = 4'd3;
    localparam logic [3:0] ST_INTERP = 4'd4;
    localparam logic [3:0] ST_IWAIT  = 4'd5;
    localparam logic [3:0] ST_POST   = 4'd6;
    localparam logic [3:0] ST_AWAIT  = 4'd7;
    localparam logic [3:0] ST_FINISH = 4'd8;

    logic [3:0]                 r_state, n_state;
    logic [CNT_W-1:0]           r_count, n_count;
    t_entry                     r_last, n_last;
    t_rec                       r_inj, n_inj;
    logic                       r_phase, n_phase;
    logic                       r_ov, n_ov;
    logic [ACT_W-1:0]           r_act, n_act;
    logic [POS_W-1:0]           r_x, n_x;
    logic [POS_W-1:0]           r_xu, n_xu;
    logic [VAL_W-1:0]           r_y, n_y;
    logic signed [APROD_W-1:0]  r_aprod, n_aprod;
    t_rec                       r_hit, n_hit;
    logic signed [INTERP_W-1:0] r_interp, n_interp;
    logic signed [INTERP_W-1:0] r_ahi, n_ahi;
    logic signed [AREA_W-1:0]   r_res, n_res;
    logic [STAT_W-1:0]          r_stat, n_stat;
    logic signed [AREA_W-1:0]   r_out_val, n_out_val;
    logic [STAT_W-1:0]          r_out_stat, n_out_stat;

    t_rec                       rec_chain [TABLE_DEPTH];
    t_entry                     ent_chain [TABLE_DEPTH];
    logic                       vld_chain [TABLE_DEPTH];
    logic                       wr_en;
    t_entry                     wr_entry;

    t_md_req                    md_req;
    logic                       md_done;
    logic [Q_W-1:0]             md_q;

    logic [NUM_W-1:0]           a_ysum;
    logic signed [NUM_W-1:0]    a_dx;
    logic signed [APROD_W-1:0]  a_prod;
    logic signed [APROD_W-1:0]  a_step;
    logic signed [WIDE_W-1:0]   a_sum;
    logic signed [INTERP_W-1:0] hit_d;
    logic [MAG_W-1:0]           hit_mag;
    logic signed [INTERP_W-1:0] interp_res;
    logic signed [INTERP_W-1:0] avg_d;
    logic [MAG_W-1:0]           avg_mag;
    logic signed [NUM_W-1:0]    avg_w;
    logic [NUM_W-1:0]           avg_den;
    logic                       avg_neg;
    logic [Q_W-1:0]             avg_qc;
    logic signed [AREA_W-1:0]   avg_res;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            t_rec   c_rec_in;
            t_entry c_next;
            logic   c_next_vld;
            if (gi == 0) begin : g_head
                assign c_rec_in = r_inj;
            end else begin : g_body
                assign c_rec_in = rec_chain[gi-1];
            end
            if (gi == TABLE_DEPTH - 1) begin : g_tail
                assign c_next     = '0;
                assign c_next_vld = 1'b0;
            end else begin : g_link
                assign c_next     = ent_chain[gi+1];
                assign c_next_vld = vld_chain[gi+1];
            end
            plti_cell #(
                .IDX       (gi),
                .IDX_W     (IDX_W),
                .RESET_VAL (RESET_VAL)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_wr_en      (wr_en),
                .i_wr_idx     (r_count[IDX_W-1:0]),
                .i_wr_entry   (wr_entry),
                .i_rec        (c_rec_in),
                .i_next_entry (c_next),
                .i_next_valid (c_next_vld),
                .o_rec        (rec_chain[gi]),
                .o_entry      (ent_chain[gi]),
                .o_valid      (vld_chain[gi])
            );
        end
    endgenerate

    plti_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_done  (md_done),
        .o_quot  (md_q)
    );

    // datapath
    always_comb begin
        a_ysum  = NUM_W'(r_last.val) + NUM_W'(r_y);
        a_dx    = $signed(NUM_W'(r_x)) - $signed(NUM_W'(r_last.pos));
        a_prod  = $signed({1'b0, a_ysum}) * a_dx;
        a_step  = r_aprod >>> (FRACTION_BITS + 1);
        a_sum   = WIDE_W'(r_last.area) + WIDE_W'(a_step);

        hit_d   = INTERP_W'(r_hit.e1) - INTERP_W'(r_hit.e0);
        hit_mag = hit_d[INTERP_W-1] ? MAG_W'(-hit_d) : MAG_W'(hit_d);
        interp_res = hit_d[INTERP_W-1] ?
            INTERP_W'(r_hit.e0) - $signed({1'b0, md_q}) :
            INTERP_W'(r_hit.e0) + $signed({1'b0, md_q});

        avg_d   = r_ahi - r_interp;
        avg_mag = avg_d[INTERP_W-1] ? MAG_W'(-avg_d) : MAG_W'(avg_d);
        avg_w   = $signed(NUM_W'(r_xu)) - $signed(NUM_W'(r_x));
        avg_den = avg_w[NUM_W-1] ? NUM_W'(-avg_w) : NUM_W'(avg_w);
        avg_neg = avg_d[INTERP_W-1] ^ avg_w[NUM_W-1];
        avg_qc  = (md_q > AVG_LIM) ? AVG_LIM : md_q;
        avg_res = sat_area(avg_neg ? -$signed(WIDE_W'(avg_qc)) : $signed(WIDE_W'(avg_qc)));

        wr_en         = (r_state == ST_AADD);
        wr_entry.pos  = r_x;
        wr_entry.val  = r_y;
        wr_entry.area = sat_area(a_sum);

        md_req.start = 1'b0;
        if (r_state == ST_POST) begin
            md_req.mag = avg_mag;
            md_req.num = NUM_W'(1) << FRACTION_BITS;
            md_req.den = avg_den;
        end else begin
            md_req.mag = hit_mag;
            md_req.num = NUM_W'(r_hit.x - r_hit.lo);
            md_req.den = NUM_W'(r_hit.hi - r_hit.lo);
        end
        if (r_state == ST_INTERP && r_hit.found) begin
            md_req.start = 1'b1;
        end
        if (r_state == ST_POST && r_act == ACT_AVERAGE && r_phase) begin
            md_req.start = 1'b1;
        end
    end

    // control
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_last     = r_last;
        n_inj      = r_inj;
        n_inj.active = 1'b0;
        n_phase    = r_phase;
        n_ov       = r_ov;
        n_act      = r_act;
        n_x        = r_x;
        n_xu       = r_xu;
        n_y        = r_y;
        n_aprod    = r_aprod;
        n_hit      = r_hit;
        n_interp   = r_interp;
        n_ahi      = r_ahi;
        n_res      = r_res;
        n_stat     = r_stat;
        n_out_val  = r_out_val;
        n_out_stat = r_out_stat;

        if (r_ov && o_rsp.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_act   = i_req.action;
                    n_x     = i_req.position;
                    n_xu    = i_req.upper_position;
                    n_y     = i_req.point_value;
                    n_res   = '0;
                    n_stat  = STAT_OK;
                    n_phase = 1'b0;
                    n_inj.found = 1'b0;
                    unique case (i_req.action)
                        ACT_APPEND: begin
                            if (r_count == CNT_W'(TABLE_DEPTH)) begin
                                n_stat  = STAT_FULL;
                                n_state = ST_FINISH;
                            end else begin
                                n_state = ST_AMUL;
                            end
                        end
                        ACT_VALUE: begin
                            n_inj.active   = 1'b1;
                            n_inj.use_area = 1'b0;
                            n_inj.x        = i_req.position;
                            n_state        = ST_SCAN;
                        end
                        ACT_AVERAGE: begin
                            if (i_req.upper_position == i_req.position) begin
                                n_stat  = STAT_ZERO_WIDTH;
                                n_state = ST_FINISH;
                            end else begin
                                n_inj.active   = 1'b1;
                                n_inj.use_area = 1'b1;
                                n_inj.x        = i_req.upper_position;
                                n_state        = ST_SCAN;
                            end
                        end
                        default: begin
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_AMUL: begin
                n_aprod = a_prod;
                n_state = ST_AADD;
            end
            ST_AADD: begin
                n_last  = wr_entry;
                n_count = r_count + 1'b1;
                n_state = ST_FINISH;
            end
            ST_SCAN: begin
                if (rec_chain[TABLE_DEPTH-1].active) begin
                    n_hit   = rec_chain[TABLE_DEPTH-1];
                    n_state = ST_INTERP;
                end
            end
            ST_INTERP: begin
                if (r_hit.found) begin
                    n_state = ST_IWAIT;
                end else begin
                    n_interp = INTERP_W'(r_hit.e0);
                    n_state  = ST_POST;
                end
            end
            ST_IWAIT: begin
                if (md_done) begin
                    n_interp = interp_res;
                    n_state  = ST_POST;
                end
            end
            ST_POST: begin
                if (r_act == ACT_VALUE) begin
                    n_res   = sat_area(WIDE_W'(r_interp));
                    n_state = ST_FINISH;
                end else if (!r_phase) begin
                    n_ahi          = r_interp;
                    n_phase        = 1'b1;
                    n_inj.active   = 1'b1;
                    n_inj.use_area = 1'b1;
                    n_inj.found    = 1'b0;
                    n_inj.x        = r_x;
                    n_state        = ST_SCAN;
                end else begin
                    n_state = ST_AWAIT;
                end
            end
            ST_AWAIT: begin
                if (md_done) begin
                    n_res   = avg_res;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov       = 1'b1;
                    n_out_val  = r_res;
                    n_out_stat = r_stat;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= CNT_W'(1);
            r_last.pos   <= '0;
            r_last.val   <= RESET_VAL;
            r_last.area  <= '0;
            r_inj        <= '0;
            r_phase      <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_last       <= n_last;
            r_inj        <= n_inj;
            r_phase      <= n_phase;
            r_ov         <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_x        <= n_x;
        r_xu       <= n_xu;
        r_y        <= n_y;
        r_aprod    <= n_aprod;
        r_hit      <= n_hit;
        r_interp   <= n_interp;
        r_ahi      <= n_ahi;
        r_res      <= n_res;
        r_stat     <= n_stat;
        r_out_val  <= n_out_val;
        r_out_stat <= n_out_stat;
    end

    assign i_req.ready        = (r_state == ST_IDLE);
    assign o_rsp.valid        = r_ov;
    assign o_rsp.result_value = r_out_val;
    assign o_rsp.status       = r_out_stat;

    `PLTI_ASSERT_CLK(a_reset_idle, i_clk, !i_rst_n |=> (r_state == ST_IDLE && !r_ov))
    `PLTI_ASSERT(a_md_done_wait, i_clk, i_rst_n, md_done |-> (r_state == ST_IWAIT || r_state == ST_AWAIT))
    `PLTI_ASSERT(a_scan_exit, i_clk, i_rst_n, rec_chain[TABLE_DEPTH-1].active |-> r_state == ST_SCAN)
    `PLTI_ASSERT(a_count_range, i_clk, i_rst_n, r_count != '0 && r_count <= CNT_W'(TABLE_DEPTH))
    `PLTI_ASSERT(a_one_request, i_clk, i_rst_n, (i_req.valid && i_req.ready) |=> !i_req.ready)

endmodule

// ----- tb/piecewise_linear_table_interpolator_core_tb.sv -----
// testbench of the table interpolator: directed table, random requests, predicted results
module piecewise_linear_table_interpolator_core_tb;
    import plti_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 256;
    localparam int FRAC = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM = 200;
    localparam longint MAXA = 64'sh7F_FFFF_FFFF;
    localparam longint MINA = -64'sh80_0000_0000;

    typedef struct {
        logic [ACT_W-1:0] act;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] xu;
        logic [VAL_W-1:0] y;
    } t_req;

    typedef struct {
        logic signed [AREA_W-1:0] value;
        logic [STAT_W-1:0]        status;
    } t_res;

    typedef struct {
        t_req req;
        bit   known;
        t_res res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    plti_req_if req_ch ();
    plti_rsp_if rsp_ch ();

    piecewise_linear_table_interpolator_core #(.TABLE_DEPTH(DEPTH), .FRACTION_BITS(FRAC)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source)
    );

    logic [POS_W-1:0] tbl_pos [DEPTH];
    logic [VAL_W-1:0] tbl_val [DEPTH];
    longint           tbl_area [DEPTH];
    int               tbl_count;

    t_res pending_results [$];
    int   fail_count;
    int   idle_cycles;
    bit   rsp_quiet;

    function automatic longint clamp40(longint v);
        if (v > MAXA) return MAXA;
        if (v < MINA) return MINA;
        return v;
    endfunction

    function automatic longint floor_shift(longint v, int s);
        longint r;
        r = v >>> s;
        return r;
    endfunction

    function automatic longint scaled_ratio(longint a, longint n, longint den);
        longint hi, lo, p, qh, rh;
        hi = a >> 20;
        lo = a & 64'hF_FFFF;
        p = hi * n;
        qh = p / den;
        rh = p % den;
        if (qh >= (64'sd1 <<< 42)) return 64'sd1 <<< 62;
        return (qh <<< 20) + (((rh <<< 20) + lo * n) / den);
    endfunction

    function automatic longint table_entry(bit use_area, int i);
        return use_area ? tbl_area[i] : longint'(tbl_val[i]);
    endfunction

    function automatic longint lookup(bit use_area, logic [POS_W-1:0] x);
        longint v0, d, mag, q;
        for (int i = 0; i + 1 < tbl_count; i++) begin
            if (tbl_pos[i] <= x && x < tbl_pos[i+1]) begin
                v0 = table_entry(use_area, i);
                d = table_entry(use_area, i + 1) - v0;
                mag = d < 0 ? -d : d;
                q = scaled_ratio(mag, longint'(x - tbl_pos[i]),
                                 longint'(tbl_pos[i+1] - tbl_pos[i]));
                return d < 0 ? v0 - q : v0 + q;
            end
        end
        return table_entry(use_area, tbl_count - 1);
    endfunction

    function automatic t_res table_apply(t_req r);
        t_res o;
        longint ysum, dx, diff, w, dm, wm, q;
        bit neg;
        o.value = '0;
        o.status = STAT_OK;
        if (r.act == ACT_APPEND) begin
            if (tbl_count >= DEPTH) begin
                o.status = STAT_FULL;
            end else begin
                ysum = longint'(tbl_val[tbl_count-1]) + longint'(r.y);
                dx = longint'(r.x) - longint'(tbl_pos[tbl_count-1]);
                tbl_pos[tbl_count] = r.x;
                tbl_val[tbl_count] = r.y;
                tbl_area[tbl_count] = clamp40(tbl_area[tbl_count-1]
                                              + floor_shift(ysum * dx, FRAC + 1));
                tbl_count++;
            end
        end else if (r.act == ACT_VALUE) begin
            o.value = AREA_W'(clamp40(lookup(1'b0, r.x)));
        end else if (r.act == ACT_AVERAGE) begin
            if (r.xu == r.x) begin
                o.status = STAT_ZERO_WIDTH;
            end else begin
                diff = lookup(1'b1, r.xu) - lookup(1'b1, r.x);
                w = longint'(r.xu) - longint'(r.x);
                neg = (diff < 0) != (w < 0);
                dm = diff < 0 ? -diff : diff;
                wm = w < 0 ? -w : w;
                q = scaled_ratio(dm, 64'sd1 <<< FRAC, wm);
                if (q > MAXA + 1) q = MAXA + 1;
                o.value = AREA_W'(clamp40(neg ? -q : q));
            end
        end
        return o;
    endfunction

    function automatic t_req rand_request(bit allow_append);
        t_req r;
        int k;
        k = $urandom_range(0, 9);
        if (!allow_append && k < 3) k = 3 + $urandom_range(0, 6);
        r.act = k < 3 ? ACT_APPEND : (k < 6 ? ACT_VALUE : (k < 9 ? ACT_AVERAGE : 2'd3));
        r.x = $urandom_range(0, 15) == 0 ? POS_W'($urandom) : POS_W'($urandom_range(0, 24'h10_0000));
        r.xu = $urandom_range(0, 15) == 0 ? r.x : POS_W'($urandom);
        if ($urandom_range(0, 3) != 0) r.xu = POS_W'($urandom_range(0, 24'h10_0000));
        r.y = VAL_W'($urandom);
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side: random stall bursts, checks against the oldest prediction
    initial begin
        int gap;
        t_res e;
        rsp_ch.ready = 1'b0;
        gap = 0;
        @(negedge i_clk);
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result value=%0d status=%0d",
                           rsp_ch.result_value, rsp_ch.status);
                    fail_count++;
                end else begin
                    e = pending_results.pop_front();
                    if (rsp_ch.result_value !== e.value) begin
                        $error("result_value expected %0d actual %0d", e.value,
                               rsp_ch.result_value);
                        fail_count++;
                    end
                    if (rsp_ch.status !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, rsp_ch.status);
                        fail_count++;
                    end
                end
            end
            @(negedge i_clk);
            if (rsp_quiet) begin
                rsp_ch.ready <= 1'b1;
            end else if (gap > 0) begin
                gap--;
                rsp_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 17) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on accepted requests and results
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                idle_cycles = 0;
            end else if (++idle_cycles >= IDLE_LIMIT) begin
                $display("piecewise_linear_table_interpolator_core: mismatch");
                $finish;
            end
        end
    end

    task automatic send_request(t_req r, bit quiet, output bit accepted_dummy);
        int gap;
        gap = quiet ? 0 : ($urandom_range(0, 4) == 0 ? $urandom_range(1, 17) : 0);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.action <= r.act;
        req_ch.position <= r.x;
        req_ch.upper_position <= r.xu;
        req_ch.point_value <= r.y;
        req_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        accepted_dummy = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic issue(t_req r, bit quiet, bit known, t_res res);
        t_res p;
        t_res expect_res;
        bit acc;
        p = table_apply(r);
        if (known && (p.value !== res.value || p.status !== res.status)) begin
            $error("directed row disagrees with prediction");
            fail_count++;
        end
        expect_res = known ? res : p;
        pending_results = {pending_results, expect_res};
        send_request(r, quiet, acc);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    t_row directed [$];

    function automatic t_row row(logic [1:0] a, int x, int xu, int y, bit k,
                                 longint v, logic [1:0] s);
        t_row w;
        w.req = '{a, POS_W'(x), POS_W'(xu), VAL_W'(y)};
        w.known = k;
        w.res = '{AREA_W'(v), s};
        return w;
    endfunction

    task automatic add_row(t_row w);
        directed = {directed, w};
    endtask

    initial begin
        t_req r;
        t_res none;
        fail_count = 0;
        rsp_quiet = 1'b0;
        none = '{'0, STAT_OK};
        req_ch.valid = 1'b0;
        req_ch.action = ACT_APPEND;
        req_ch.position = '0;
        req_ch.upper_position = '0;
        req_ch.point_value = '0;
        i_rst_n = 1'b0;
        tbl_pos[0] = '0;
        tbl_val[0] = VAL_W'(1 << FRAC);
        tbl_area[0] = 0;
        tbl_count = 1;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // single entry after reset, then appends and queries over the grown table
        add_row(row(ACT_VALUE, 0, 0, 0, 1, 1 << FRAC, STAT_OK));
        add_row(row(ACT_VALUE, 24'hFF_FFFF, 0, 0, 1, 1 << FRAC, STAT_OK));
        add_row(row(ACT_AVERAGE, 5, 5, 0, 1, 0, STAT_ZERO_WIDTH));
        add_row(row(ACT_AVERAGE, 0, 24'hFF_FFFF, 0, 1, 0, STAT_OK));
        add_row(row(2'd3, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1, 0, STAT_OK));
        add_row(row(ACT_APPEND, 24'h1_0000, 0, 24'hFF_FFFF, 1, 0, STAT_OK));
        add_row(row(ACT_APPEND, 24'hFF_FFFF, 0, 0, 1, 0, STAT_OK));
        add_row(row(ACT_APPEND, 24'h8_0000, 0, 24'h2_0000, 1, 0, STAT_OK));
        add_row(row(ACT_APPEND, 24'hFF_FFFF, 0, 24'hFF_FFFF, 1, 0, STAT_OK));
        add_row(row(ACT_VALUE, 24'h8000, 0, 0, 0, 0, STAT_OK));
        add_row(row(ACT_VALUE, 24'h1_0000, 0, 0, 0, 0, STAT_OK));
        add_row(row(ACT_VALUE, 24'hFF_FFFE, 0, 0, 0, 0, STAT_OK));
        add_row(row(ACT_VALUE, 24'hFF_FFFF, 0, 0, 0, 0, STAT_OK));
        add_row(row(ACT_AVERAGE, 0, 24'h1_0000, 0, 0, 0, STAT_OK));
        add_row(row(ACT_AVERAGE, 24'hFF_FFFF, 0, 0, 0, 0, STAT_OK));
        add_row(row(ACT_AVERAGE, 24'h9_0000, 24'h9_0001, 0, 0, 0, STAT_OK));
        add_row(row(ACT_AVERAGE, 24'hFF_FFFF, 24'hFF_FFFF, 0, 1, 0, STAT_ZERO_WIDTH));
        foreach (directed[i]) issue(directed[i].req, 1'b0, directed[i].known, directed[i].res);

        // hold off until everything has come back
        drain();

        // fill the table to the top, then overflow, then random requests
        while (tbl_count < DEPTH) begin
            r = rand_request(1'b1);
            r.act = ACT_APPEND;
            issue(r, 1'b0, 1'b0, none);
        end
        r = rand_request(1'b1);
        r.act = ACT_APPEND;
        issue(r, 1'b0, 1'b1, '{'0, STAT_FULL});
        for (int i = 0; i < 20; i++) issue(rand_request(1'b0), 1'b0, 1'b0, none);
        drain();

        // mostly queries over the full table; last part with no idling
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 60) rsp_quiet = 1'b1;
            issue(rand_request(1'b1), i >= N_RANDOM - 60, 1'b0, none);
        end
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (1200) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("piecewise_linear_table_interpolator_core: match");
        end else begin
            $display("piecewise_linear_table_interpolator_core: mismatch");
        end
        $finish;
    end
endmodule
